[src/ndtf_pkg.sv]
`timescale 1ns / 1ps

package ndtf_pkg;

  localparam int STACK_DEPTH   = 16;
  localparam int POSITION_BITS = 16;
  localparam int MAX_PAIRS     = 4;

  localparam int FILL_W   = $clog2(STACK_DEPTH + 1);
  localparam int SIDX_W   = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int BYTE_W   = 8;
  localparam int SRCPOS_W = 16;
  localparam int PAIRS_W  = 64;
  localparam int PCOUNT_W = 3;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_RANGE_PAIRS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PAIR_COUNT  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CASE_FOLD   = 2'd2;

  typedef struct packed {
    logic [BYTE_W-1:0] raw_byte;
    logic [BYTE_W-1:0] folded_byte;
    logic              start;
    logic              skip;
    logic              is_open;
    logic [BYTE_W-1:0] closer;
  } cls_word_t;

endpackage

[src/ndtf_front.sv]
`timescale 1ns / 1ps

module ndtf_front (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [ndtf_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [ndtf_pkg::PAIRS_W-1:0]    cfg_data,
  input  logic [ndtf_pkg::BYTE_W-1:0]     text_byte,
  input  logic                            start_of_text,
  input  logic                            skip_byte,
  output ndtf_pkg::cls_word_t             cls_word
);
  import ndtf_pkg::*;

  logic [PAIRS_W-1:0]  range_pairs_r;
  logic [PCOUNT_W-1:0] pair_count_r;
  logic                case_fold_r;
  logic [PCOUNT_W-1:0] used_pairs;
  logic [BYTE_W-1:0]   opener;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      range_pairs_r <= '0;
      pair_count_r  <= '0;
      case_fold_r   <= 1'b0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_RANGE_PAIRS: range_pairs_r <= cfg_data;
        CFG_PAIR_COUNT:  pair_count_r  <= cfg_data[PCOUNT_W-1:0];
        CFG_CASE_FOLD:   case_fold_r   <= cfg_data[0];
        default: ;
      endcase
    end
  end

  assign used_pairs = (pair_count_r > PCOUNT_W'(MAX_PAIRS)) ? PCOUNT_W'(MAX_PAIRS)
                                                             : pair_count_r;

  // first matching pair wins: scan downward so the lowest index lands last
  always_comb begin
    cls_word.raw_byte = text_byte;
    cls_word.start    = start_of_text;
    cls_word.skip     = skip_byte;
    cls_word.is_open  = 1'b0;
    cls_word.closer   = '0;
    opener            = '0;
    for (int k = MAX_PAIRS - 1; k >= 0; k--) begin
      opener = range_pairs_r[16*k+8 +: BYTE_W];
      if ((PCOUNT_W'(k) < used_pairs) && (text_byte == opener)) begin
        cls_word.is_open = 1'b1;
        cls_word.closer  = range_pairs_r[16*k +: BYTE_W];
      end
    end
    if (case_fold_r && (text_byte >= 8'h41) && (text_byte <= 8'h5A)) begin
      cls_word.folded_byte = text_byte + 8'h20;
    end else begin
      cls_word.folded_byte = text_byte;
    end
  end

endmodule

[src/ndtf_queue.sv]
`timescale 1ns / 1ps

module ndtf_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                wr_en,
  input  ndtf_pkg::cls_word_t wr_word,
  output logic                full,
  input  logic                rd_en,
  output ndtf_pkg::cls_word_t rd_word,
  output logic                not_empty
);
  import ndtf_pkg::*;

  cls_word_t          mem_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0]  count_r, count_nxt;
  logic               do_wr, do_rd;

  assign full      = (count_r == QCNT_W'(QUEUE_DEPTH));
  assign not_empty = (count_r != '0);
  assign do_wr     = wr_en && !full;
  assign do_rd     = rd_en && not_empty;
  assign rd_word   = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_wr) begin
      wr_ptr_nxt = (wr_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_rd) begin
      rd_ptr_nxt = (rd_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    case ({do_wr, do_rd})
      2'b10:   count_nxt = count_r + 1'b1;
      2'b01:   count_nxt = count_r - 1'b1;
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem_r[wr_ptr_r] <= wr_word;
    end
  end

endmodule

[src/ndtf_back.sv]
`timescale 1ns / 1ps

module ndtf_back (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             item_valid,
  input  ndtf_pkg::cls_word_t              item,
  output logic                             item_pop,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [ndtf_pkg::BYTE_W-1:0]      out_byte,
  output logic [ndtf_pkg::SRCPOS_W-1:0]    out_position,
  output logic                             out_overflow
);
  import ndtf_pkg::*;

  logic [BYTE_W-1:0]        stack_r [STACK_DEPTH];
  logic [BYTE_W-1:0]        stack_nxt [STACK_DEPTH];
  logic [FILL_W-1:0]        fill_r, fill_nxt, fill_eff;
  logic [POSITION_BITS-1:0] pos_r, pos_nxt, pos_eff;
  logic                     ovf_r, ovf_nxt, ovf_eff;
  logic                     out_valid_r, out_valid_nxt;
  logic [BYTE_W-1:0]        out_byte_r, out_byte_nxt;
  logic [SRCPOS_W-1:0]      out_pos_r, out_pos_nxt;
  logic                     out_ovf_r, out_ovf_nxt;
  logic                     hit;
  logic [SIDX_W-1:0]        hit_idx;

  assign item_pop     = item_valid && (!out_valid_r || out_ready);
  assign out_valid    = out_valid_r;
  assign out_byte     = out_byte_r;
  assign out_position = out_pos_r;
  assign out_overflow = out_ovf_r;

  always_comb begin
    fill_eff = item.start ? '0 : fill_r;
    pos_eff  = item.start ? '0 : pos_r;
    ovf_eff  = item.start ? 1'b0 : ovf_r;

    // topmost live entry that matches
    hit     = 1'b0;
    hit_idx = '0;
    for (int i = 0; i < STACK_DEPTH; i++) begin
      if ((FILL_W'(i) < fill_eff) && (stack_r[i] == item.raw_byte)) begin
        hit     = 1'b1;
        hit_idx = SIDX_W'(i);
      end
    end

    for (int i = 0; i < STACK_DEPTH; i++) begin
      stack_nxt[i] = stack_r[i];
    end
    fill_nxt      = fill_r;
    pos_nxt       = pos_r;
    ovf_nxt       = ovf_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_byte_nxt  = out_byte_r;
    out_pos_nxt   = out_pos_r;
    out_ovf_nxt   = out_ovf_r;

    if (item_pop) begin
      fill_nxt = fill_eff;
      ovf_nxt  = ovf_eff;
      pos_nxt  = (pos_eff == {POSITION_BITS{1'b1}}) ? pos_eff : pos_eff + 1'b1;
      if (hit) begin
        // drop the matched entry, pull the ones above it down
        for (int i = 0; i < STACK_DEPTH - 1; i++) begin
          if (SIDX_W'(i) >= hit_idx) begin
            stack_nxt[i] = stack_r[i+1];
          end
        end
        fill_nxt = fill_eff - 1'b1;
      end else if (item.is_open) begin
        if (fill_eff < FILL_W'(STACK_DEPTH)) begin
          for (int i = 0; i < STACK_DEPTH; i++) begin
            if (FILL_W'(i) == fill_eff) begin
              stack_nxt[i] = item.closer;
            end
          end
          fill_nxt = fill_eff + 1'b1;
        end else begin
          ovf_nxt = 1'b1;
        end
      end else if ((fill_eff == '0) && !item.skip) begin
        out_valid_nxt = 1'b1;
        out_byte_nxt  = item.folded_byte;
        out_pos_nxt   = pos_eff[SRCPOS_W-1:0];
        out_ovf_nxt   = ovf_eff;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r      <= '0;
      pos_r       <= '0;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      fill_r      <= fill_nxt;
      pos_r       <= pos_nxt;
      ovf_r       <= ovf_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < STACK_DEPTH; i++) begin
      stack_r[i] <= stack_nxt[i];
    end
    out_byte_r <= out_byte_nxt;
    out_pos_r  <= out_pos_nxt;
    out_ovf_r  <= out_ovf_nxt;
  end

endmodule

[src/nested_delimiter_text_filter_core.sv]
`timescale 1ns / 1ps

// Nested-delimiter text filter.
// in_*  : one text word per handshake; tdata = text byte, tuser = start, skip.
// out_* : kept bytes (optionally lowercased) with their source position and
//         the sticky overflow flag.
// cfg_* : register writes; index 0 delimiter pairs, 1 pair count, 2 case fold.
//         Write only while the block is idle; cfg_ready is always high.
// Each word is classified against the opener table on entry, queued in a
// two-entry queue, and then resolved against the closer stack (16 entries,
// compared in parallel) by the back end, one word per cycle unless out_* stalls.
// Throughput: one word per cycle while out_tready stays high.
// A kept byte is written into the queue, then into the result register, and is then shown on out_*.
// When out_tvalid is high and out_tready low the result register holds, the queue fills and
// in_tready drops once both queue slots are taken.
// Reset (rst_n low at a clock edge) empties the queue, the stack and the
// result register, zeroes the position and overflow flag and clears the
// configuration registers.
module nested_delimiter_text_filter_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] text_byte
  input  logic [1:0]  in_tuser,   // [0] start_of_text, [1] skip_byte
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // [7:0] out_byte, [23:8] source_position
  output logic [0:0]  out_tuser,  // [0] stack_overflowed
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [ndtf_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [ndtf_pkg::PAIRS_W-1:0]   cfg_data
);
  import ndtf_pkg::*;

  cls_word_t             cls_word;
  cls_word_t             q_word;
  logic                  q_full;
  logic                  q_not_empty;
  logic                  q_pop;
  logic [BYTE_W-1:0]     res_byte;
  logic [SRCPOS_W-1:0]   res_pos;
  logic                  res_ovf;

  assign in_tready = !q_full;
  assign out_tdata = {res_pos, res_byte};
  assign out_tuser = res_ovf;

  ndtf_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .text_byte     (in_tdata),
    .start_of_text (in_tuser[0]),
    .skip_byte     (in_tuser[1]),
    .cls_word      (cls_word)
  );

  ndtf_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .wr_en     (in_tvalid),
    .wr_word   (cls_word),
    .full      (q_full),
    .rd_en     (q_pop),
    .rd_word   (q_word),
    .not_empty (q_not_empty)
  );

  ndtf_back u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .item_valid   (q_not_empty),
    .item         (q_word),
    .item_pop     (q_pop),
    .out_valid    (out_tvalid),
    .out_ready    (out_tready),
    .out_byte     (res_byte),
    .out_position (res_pos),
    .out_overflow (res_ovf)
  );

endmodule
